[sv/rcfe_pkg.sv]
// shared types, constants and the crc byte update for the command frame encoder
// no dependencies; used by rcfe_admit, rcfe_emit and the top level
`default_nettype none

package rcfe_pkg;

   localparam logic [7:0]  HeaderReset = 8'h55;
   localparam logic [15:0] CrcInit     = 16'hFFFF;
   localparam logic [15:0] CrcPoly     = 16'hA001;
   localparam logic [8:0]  LenOverhead = 9'd7;

   // byte positions inside one item's run of output bytes
   localparam logic [2:0] IdxHeader  = 3'd0;
   localparam logic [2:0] IdxTotalLo = 3'd1;
   localparam logic [2:0] IdxTotalHi = 3'd2;
   localparam logic [2:0] IdxFunc    = 3'd3;
   localparam logic [2:0] IdxAddrHi  = 3'd4;
   localparam logic [2:0] IdxData    = 3'd5;
   localparam logic [2:0] IdxCrcLo   = 3'd6;
   localparam logic [2:0] IdxCrcHi   = 3'd7;

   // register select taken from csr address bit 2
   localparam logic RegHeader = 1'b0;

   typedef enum logic {
      CMD_BEGIN   = 1'b0,
      CMD_PAYLOAD = 1'b1
   } cmd_type;

   typedef struct packed {
      logic [2:0] first_idx;
      logic       with_crc;
      logic [8:0] total;
      logic [7:0] function_code;
      logic [7:0] address_high;
      logic [7:0] last_data;
   } item_type;

   // crc-16/modbus, one byte, reflected
   function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

[sv/rcfe_admit.sv]
// input decode: frame open / remaining count tracking, builds the byte run for one item
// depends on rcfe_pkg
`default_nettype none

module rcfe_admit (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic                cmd,
   input  wire logic [7:0]          function_code,
   input  wire logic [7:0]          address_high,
   input  wire logic [7:0]          address_low,
   input  wire logic [7:0]          payload_length,
   input  wire logic [7:0]          payload_byte,
   output      logic                keep,
   output      rcfe_pkg::item_type  item
);
   import rcfe_pkg::*;

   logic       frame_open_ff, frame_open_in;
   logic [7:0] remaining_ff, remaining_in;
   logic [7:0] remaining_dec;

   assign remaining_dec = remaining_ff - 8'd1;

   always_comb begin
      item               = '0;
      item.function_code = function_code;
      item.address_high  = address_high;
      item.total         = {1'b0, payload_length} + LenOverhead;
      keep               = 1'b0;
      frame_open_in      = frame_open_ff;
      remaining_in       = remaining_ff;
      case (cmd_type'(cmd))
         CMD_BEGIN: begin
            keep           = 1'b1;
            item.first_idx = IdxHeader;
            item.with_crc  = (payload_length == 8'd0);
            item.last_data = address_low;
            frame_open_in  = (payload_length != 8'd0);
            remaining_in   = payload_length;
         end
         CMD_PAYLOAD: begin
            // payload with no open frame is dropped
            keep           = frame_open_ff;
            item.first_idx = IdxData;
            item.with_crc  = (remaining_dec == 8'd0);
            item.last_data = payload_byte;
            if (frame_open_ff) begin
               frame_open_in = (remaining_dec != 8'd0);
               remaining_in  = remaining_dec;
            end
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         remaining_ff  <= 8'd0;
      end else if (accept) begin
         frame_open_ff <= frame_open_in;
         remaining_ff  <= remaining_in;
      end
   end

endmodule

`default_nettype wire

[sv/rcfe_emit.sv]
// item register, byte select with running crc, and the result output register
// depends on rcfe_pkg
`default_nettype none

module rcfe_emit (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic                keep,
   input  wire rcfe_pkg::item_type  item,
   input  wire logic [7:0]          header_byte,
   output      logic                slot_free,
   output      logic                rsp_tvalid,
   input  wire logic                rsp_tready,
   output      logic [7:0]          rsp_tdata,
   output      logic                rsp_tlast,
   output      logic                rsp_tuser
);
   import rcfe_pkg::*;

   logic        cur_valid_ff, cur_valid_in;
   logic [2:0]  idx_ff, idx_in;
   item_type    item_ff, item_in;
   logic [15:0] crc_ff, crc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_end_ff, rsp_end_in;

   logic        issue, done;
   logic [2:0]  last_idx;
   logic [7:0]  cur_byte;
   logic [15:0] crc_base;

   assign last_idx  = item_ff.with_crc ? IdxCrcHi : IdxData;
   assign issue     = cur_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign done      = issue && (idx_ff == last_idx);
   assign slot_free = !cur_valid_ff || done;
   assign crc_base  = (idx_ff == IdxHeader) ? CrcInit : crc_ff;

   always_comb begin
      case (idx_ff)
         IdxHeader:  cur_byte = header_byte;
         IdxTotalLo: cur_byte = item_ff.total[7:0];
         IdxTotalHi: cur_byte = {7'd0, item_ff.total[8]};
         IdxFunc:    cur_byte = item_ff.function_code;
         IdxAddrHi:  cur_byte = item_ff.address_high;
         IdxData:    cur_byte = item_ff.last_data;
         IdxCrcLo:   cur_byte = crc_ff[7:0];
         IdxCrcHi:   cur_byte = crc_ff[15:8];
         default:    cur_byte = 8'd0;
      endcase
   end

   always_comb begin
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      item_in      = item_ff;
      crc_in       = crc_ff;
      if (issue && (idx_ff <= IdxData)) begin
         crc_in = crc16_feed(crc_base, cur_byte);
      end
      if (accept && keep) begin
         cur_valid_in = 1'b1;
         idx_in       = item.first_idx;
         item_in      = item;
      end else if (done) begin
         cur_valid_in = 1'b0;
      end else if (issue) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_end_in   = rsp_end_ff;
      if (issue) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = cur_byte;
         rsp_last_in  = (idx_ff == last_idx);
         rsp_end_in   = (idx_ff == IdxCrcHi);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= IdxHeader;
         crc_ff       <= CrcInit;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_end_ff;

endmodule

`default_nettype wire

[sv/radar_command_frame_encoder.sv]
// serial command frame encoder with crc-16/modbus trailer, top level
// depends on rcfe_pkg, rcfe_admit and rcfe_emit
// path: an input transfer loads the item register; its first byte then passes through the result register
// throughput: one output byte per cycle unless the receiver stalls; a payload item gives its
//   data byte (and the crc pair if it closes a frame), a begin item header through data (and
//   the crc pair with an empty payload) through the single byte lane of the item register
// reset: synchronous, clears frame state, crc to 0xffff, header register to 0x55
`default_nettype none

module radar_command_frame_encoder (
   input  wire logic        clock,
   input  wire logic        reset,
   // input channel
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // function_code, address_high, address_low, payload_length, payload_byte
   input  wire logic [39:0] req_tdata,
   // cmd
   input  wire logic        req_tuser,
   // result channel
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // out_byte
   output      logic [7:0]  rsp_tdata,
   // run_last
   output      logic        rsp_tlast,
   // frame_end
   output      logic        rsp_tuser,
   // configuration port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);
   import rcfe_pkg::*;

   logic [7:0] header_byte_ff;
   logic       csr_write;
   logic       accept;
   logic       keep;
   logic       slot_free;
   item_type   item;

   // csr port: no wait states, single header register at address 0
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_byte_ff <= HeaderReset;
      end else if (csr_write && (csr_paddr[2] == RegHeader)) begin
         header_byte_ff <= csr_pwdata[7:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == RegHeader) ? {24'd0, header_byte_ff} : 32'd0;

   // an input transfer is taken whenever the item register is empty or frees this cycle
   assign req_tready = slot_free;
   assign accept     = req_tvalid && req_tready;

   // decode the item and track the open frame
   rcfe_admit u_admit (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .cmd            (req_tuser),
      .function_code  (req_tdata[7:0]),
      .address_high   (req_tdata[15:8]),
      .address_low    (req_tdata[23:16]),
      .payload_length (req_tdata[31:24]),
      .payload_byte   (req_tdata[39:32]),
      .keep           (keep),
      .item           (item)
   );

   // walk the item's bytes, update crc, drive the result register
   rcfe_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .keep        (keep),
      .item        (item),
      .header_byte (header_byte_ff),
      .slot_free   (slot_free),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

`default_nettype wire

[sv/rcfe_checker.sv]
// port-level checks for the command frame encoder, bound to the top level
// depends on radar_command_frame_encoder ports only
`default_nettype none

module rcfe_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast,
   input wire logic       rsp_tuser,
   input wire logic       csr_pready
);

   // result held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // frame end is always the last byte of its run
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("frame end without run last");

   // nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // csr port has no wait states
   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("csr ready dropped");

endmodule

bind radar_command_frame_encoder rcfe_checker u_rcfe_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser),
   .csr_pready (csr_pready)
);

`default_nettype wire
